// ===== hdl/ufb_pkg.sv =====
package ufb_pkg;

    localparam int MaxChunk = 128;
    localparam int PosW     = $clog2(MaxChunk);
    localparam int LenW     = PosW + 1;
    localparam int HdrBytes = 24;

    localparam logic [7:0] BYTE_SOF         = 8'hFB;
    localparam logic [7:0] BYTE_EOF         = 8'hFE;
    localparam logic [7:0] BYTE_ZERO        = 8'h00;
    localparam logic [7:0] BYTE_TAG         = 8'h4F;
    localparam logic [7:0] BYTE_VER         = 8'h02;
    localparam logic [7:0] BYTE_KIND_NORMAL = 8'h40;
    localparam logic [7:0] BYTE_KIND_RESEND = 8'h4F;
    localparam logic [7:0] BYTE_ADDR_UNI    = 8'h01;
    localparam logic [7:0] BYTE_ADDR_BCAST  = 8'h03;
    localparam logic [7:0] CODE_BASE_32     = 8'h33;
    localparam logic [7:0] CODE_BASE_64     = 8'h53;
    localparam logic [7:0] CODE_BASE_128    = 8'h93;
    localparam logic [7:0] CODE_PSUM_ADD    = 8'h02;

    localparam logic [1:0] SIZE_32  = 2'd0;
    localparam logic [1:0] SIZE_64  = 2'd1;
    localparam logic [1:0] SIZE_128 = 2'd2;

    localparam logic [4:0] STEP_HDR_FIRST = 5'd0;
    localparam logic [4:0] STEP_SUM_FIRST = 5'd2;
    localparam logic [4:0] STEP_HDR_LAST  = 5'd23;
    localparam logic [4:0] STEP_PAYLOAD   = 5'd24;
    localparam logic [4:0] STEP_PSUM_HI   = 5'd25;
    localparam logic [4:0] STEP_PSUM_LO   = 5'd26;
    localparam logic [4:0] STEP_FSUM_HI   = 5'd27;
    localparam logic [4:0] STEP_FSUM_LO   = 5'd28;
    localparam logic [4:0] STEP_EOF_HI    = 5'd29;
    localparam logic [4:0] STEP_EOF_LAST  = 5'd30;

    typedef enum logic [2:0] {
        REG_ECU_ID          = 3'd0,
        REG_TARGET_ID       = 3'd1,
        REG_SIZE_CODE       = 3'd2,
        REG_CHECKSUM_FORMAT = 3'd3,
        REG_BROADCAST       = 3'd4
    } ufb_reg_t;

    typedef struct packed {
        logic        first;
        logic        last;
        logic [7:0]  data;
        logic        resend;
        logic [15:0] num;
        logic [15:0] psum;
    } ufb_job_t;

    typedef struct packed {
        logic [47:0] ecu_id;
        logic [47:0] target_id;
        logic [7:0]  addr_byte;
        logic [7:0]  code_byte;
        logic        psum_en;
    } ufb_hdr_t;

    function automatic logic [1:0] eff_code(input logic [1:0] size_code);
        logic [1:0] c;
        c = (size_code > SIZE_128) ? SIZE_128 : size_code;
        for (int k = 0; k < 2; k++) begin
            if (c != SIZE_32 && (32 << c) > MaxChunk) begin
                c = c - 2'd1;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] code_byte(input logic [1:0] c, input logic fmt);
        logic [7:0] base;
        case (c)
            SIZE_32:  base = CODE_BASE_32;
            SIZE_64:  base = CODE_BASE_64;
            default:  base = CODE_BASE_128;
        endcase
        return fmt ? base + CODE_PSUM_ADD : base;
    endfunction

endpackage

// ===== hdl/ufb_serializer.sv =====
module ufb_serializer
    import ufb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_load,
    input  ufb_job_t   job,
    input  ufb_hdr_t   hdr,
    output logic       job_ready,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       frame_end
);

    logic       job_valid_reg;
    logic       job_valid_next;
    ufb_job_t   job_reg;
    logic [4:0] step_reg;
    logic [4:0] step_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] frame_byte_reg;
    logic       frame_end_reg;

    logic                    out_open;
    logic                    emit;
    logic                    last_step;
    logic                    job_done;
    logic [HdrBytes*8-1:0]   hdr_vec;
    logic [4:0]              hdr_idx;
    logic [7:0]              hdr_byte;
    logic [7:0]              cur_byte;
    logic [7:0]              kind_byte;

    always_comb
    begin
        out_open  = !out_valid_reg || !out_stall;
        emit      = job_valid_reg && out_open;
        kind_byte = job_reg.resend ? BYTE_KIND_RESEND : BYTE_KIND_NORMAL;
        hdr_vec   = {BYTE_SOF, BYTE_SOF, hdr.addr_byte, BYTE_ZERO, hdr.code_byte,
                     hdr.ecu_id, hdr.target_id, BYTE_TAG, BYTE_ZERO, BYTE_ZERO,
                     BYTE_VER, kind_byte, job_reg.num};
        hdr_idx   = STEP_HDR_LAST - step_reg;
        hdr_byte  = hdr_vec[{hdr_idx, 3'b000} +: 8];

        case (step_reg)
            STEP_PAYLOAD:  cur_byte = job_reg.data;
            STEP_PSUM_HI:  cur_byte = job_reg.psum[15:8];
            STEP_PSUM_LO:  cur_byte = job_reg.psum[7:0];
            STEP_FSUM_HI:  cur_byte = sum_reg[15:8];
            STEP_FSUM_LO:  cur_byte = sum_reg[7:0];
            STEP_EOF_HI:   cur_byte = BYTE_EOF;
            STEP_EOF_LAST: cur_byte = BYTE_EOF;
            default:       cur_byte = hdr_byte;
        endcase

        last_step = (step_reg == STEP_PAYLOAD && !job_reg.last) ||
                    (step_reg == STEP_EOF_LAST);
        job_done  = emit && last_step;
        job_ready = !job_valid_reg || job_done;

        step_next = step_reg;
        if (job_load) begin
            step_next = job.first ? STEP_HDR_FIRST : STEP_PAYLOAD;
        end else if (emit) begin
            if (step_reg == STEP_PAYLOAD) begin
                step_next = hdr.psum_en ? STEP_PSUM_HI : STEP_FSUM_HI;
            end else begin
                step_next = step_reg + 5'd1;
            end
        end

        sum_next = sum_reg;
        if (emit) begin
            if (step_reg == STEP_HDR_FIRST) begin
                sum_next = '0;
            end else if (step_reg >= STEP_SUM_FIRST && step_reg <= STEP_PSUM_LO) begin
                sum_next = sum_reg + {8'h00, cur_byte};
            end
        end

        job_valid_next = job_load ? 1'b1 : (job_done ? 1'b0 : job_valid_reg);
        out_valid_next = out_open ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_HDR_FIRST;
            sum_reg       <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
        if (emit)
        begin
            frame_byte_reg <= cur_byte;
            frame_end_reg  <= (step_reg == STEP_EOF_LAST);
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign frame_end  = frame_end_reg;

endmodule

// ===== hdl/update_frame_builder_top.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    cmd, data_byte, resend, lost_index
// out      output     out_valid / out_stall  frame_byte, frame_end
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each frame byte leaves on its own beat, one per cycle while out_stall is low.
// A payload beat in mid-chunk yields only its byte; a chunk's first beat yields the header
// and its byte, a last beat its byte and the trailer.
// The single job register ahead of the byte selector paces the input; the next
// beat is taken in the cycle its predecessor's final byte moves to the output register.
// The configuration port is always ready.
// Reset clears the position, packet counter, sums and latches, and sets the size code to 2.
module update_frame_builder_top
    import ufb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic        resend,
    input  logic [15:0] lost_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [47:0]     ecu_id_reg;
    logic [47:0]     target_id_reg;
    logic [1:0]      size_code_reg;
    logic            checksum_format_reg;
    logic            broadcast_reg;

    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;
    logic [15:0]     packet_counter_reg;
    logic [15:0]     packet_counter_next;
    logic [15:0]     payload_sum_reg;
    logic [15:0]     payload_sum_next;
    logic            resend_reg;
    logic            resend_next;
    logic [15:0]     index_reg;
    logic [15:0]     index_next;

    logic            accept;
    logic            job_load;
    logic            job_ready;
    logic [1:0]      code;
    logic [LenW-1:0] chunk_len;
    logic            first;
    logic            last;
    logic            resend_eff;
    logic [15:0]     index_eff;
    logic [15:0]     psum_new;
    ufb_job_t        job;
    ufb_hdr_t        hdr;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        accept     = in_valid && job_ready;
        in_stall   = !job_ready;
        code       = eff_code(size_code_reg);
        chunk_len  = LenW'(32 << code);
        first      = (pos_reg == '0);
        last       = ({1'b0, pos_reg} + LenW'(1)) >= chunk_len;
        resend_eff = first ? resend : resend_reg;
        index_eff  = first ? lost_index : index_reg;
        psum_new   = (first ? 16'h0000 : payload_sum_reg) + {8'h00, data_byte};

        job.first  = first;
        job.last   = last;
        job.data   = data_byte;
        job.resend = resend_eff;
        job.num    = resend_eff ? index_eff : packet_counter_reg;
        job.psum   = psum_new;

        hdr.ecu_id    = ecu_id_reg;
        hdr.target_id = target_id_reg;
        hdr.addr_byte = broadcast_reg ? BYTE_ADDR_BCAST : BYTE_ADDR_UNI;
        hdr.code_byte = code_byte(code, checksum_format_reg);
        hdr.psum_en   = checksum_format_reg;

        job_load            = accept && !cmd;
        pos_next            = pos_reg;
        packet_counter_next = packet_counter_reg;
        payload_sum_next    = payload_sum_reg;
        resend_next         = resend_reg;
        index_next          = index_reg;

        if (accept && cmd) begin
            pos_next            = '0;
            packet_counter_next = '0;
            payload_sum_next    = '0;
            resend_next         = 1'b0;
            index_next          = '0;
        end else if (job_load) begin
            pos_next         = last ? '0 : pos_reg + PosW'(1);
            payload_sum_next = psum_new;
            resend_next      = resend_eff;
            index_next       = index_eff;
            if (last && !resend_eff) begin
                packet_counter_next = packet_counter_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecu_id_reg          <= '0;
            target_id_reg       <= '0;
            size_code_reg       <= SIZE_128;
            checksum_format_reg <= 1'b0;
            broadcast_reg       <= 1'b0;
            pos_reg             <= '0;
            packet_counter_reg  <= '0;
            payload_sum_reg     <= '0;
            resend_reg          <= 1'b0;
            index_reg           <= '0;
        end
        else
        begin
            pos_reg            <= pos_next;
            packet_counter_reg <= packet_counter_next;
            payload_sum_reg    <= payload_sum_next;
            resend_reg         <= resend_next;
            index_reg          <= index_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ECU_ID:          ecu_id_reg          <= cfg_data;
                    REG_TARGET_ID:       target_id_reg       <= cfg_data;
                    REG_SIZE_CODE:       size_code_reg       <= cfg_data[1:0];
                    REG_CHECKSUM_FORMAT: checksum_format_reg <= cfg_data[0];
                    REG_BROADCAST:       broadcast_reg       <= cfg_data[0];
                    default:             ;
                endcase
            end
        end
    end

    ufb_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_load   (job_load),
        .job        (job),
        .hdr        (hdr),
        .job_ready  (job_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_end  (frame_end)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ufb_pkg::*;

    localparam int          IdleLimit  = 4000;
    localparam int          DrainWait  = 40;
    localparam logic [1:0]  SIZE_OVER  = 2'd3;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       fend;
    } frame_beat_t;

    typedef enum {CHECK_MODEL, CHECK_NONE, CHECK_ECHO, DO_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        cmd;
        logic [7:0]  data;
        logic        resend;
        logic [15:0] lost;
        ufb_reg_t    idx;
        logic [47:0] val;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [7:0]  data_byte;
    logic        resend;
    logic [15:0] lost_index;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    logic [47:0] cur_ecu;
    logic [47:0] cur_target;
    logic [1:0]  cur_size;
    logic        cur_fmt;
    logic        cur_bcast;

    logic [7:0]  chunk_pos;
    logic [15:0] next_pkt;
    logic [15:0] fsum;
    logic [15:0] psum;
    logic        resend_q;
    logic [15:0] index_q;

    frame_beat_t step_beats[$];
    frame_beat_t frame_q[$];
    plan_row_t   plan[$];

    int mismatch_cnt = 0;
    int rand_items   = 0;
    int burst_left   = 5;
    int idle_cycles  = 0;
    int stall_left   = 0;
    int stall_mode   = 0;

    update_frame_builder_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .resend     (resend),
        .lost_index (lost_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void emit(input logic [7:0] b, input logic e);
        step_beats.push_back('{fbyte: b, fend: e});
    endfunction

    function automatic void emit_summed(input logic [7:0] b);
        fsum = fsum + 16'(b);
        emit(b, 1'b0);
    endfunction

    function automatic void predict_item(input logic c, input logic [7:0] d,
                                         input logic r, input logic [15:0] l);
        logic [1:0]  sz;
        logic [7:0]  code;
        logic [15:0] num;
        int          clen;
        step_beats.delete();
        if (c) begin
            next_pkt  = '0;
            chunk_pos = '0;
            fsum      = '0;
            psum      = '0;
            resend_q  = 1'b0;
            index_q   = '0;
            return;
        end
        sz = (cur_size > SIZE_128) ? SIZE_128 : cur_size;
        while (sz != SIZE_32 && (32 << sz) > MaxChunk) sz = sz - 2'd1;
        clen = 32 << sz;
        if (chunk_pos == 0) begin
            resend_q = r;
            index_q  = l;
            fsum     = '0;
            psum     = '0;
            code = (sz == SIZE_32) ? CODE_BASE_32 : (sz == SIZE_64) ? CODE_BASE_64 : CODE_BASE_128;
            if (cur_fmt) code = code + CODE_PSUM_ADD;
            emit(BYTE_SOF, 1'b0);
            emit(BYTE_SOF, 1'b0);
            emit_summed(cur_bcast ? BYTE_ADDR_BCAST : BYTE_ADDR_UNI);
            emit_summed(BYTE_ZERO);
            emit_summed(code);
            for (int i = 0; i < 6; i++) emit_summed(cur_ecu[47 - 8 * i -: 8]);
            for (int i = 0; i < 6; i++) emit_summed(cur_target[47 - 8 * i -: 8]);
            emit_summed(BYTE_TAG);
            emit_summed(BYTE_ZERO);
            emit_summed(BYTE_ZERO);
            emit_summed(BYTE_VER);
            emit_summed(resend_q ? BYTE_KIND_RESEND : BYTE_KIND_NORMAL);
            num = resend_q ? index_q : next_pkt;
            emit_summed(num[15:8]);
            emit_summed(num[7:0]);
        end
        emit_summed(d);
        psum = psum + 16'(d);
        if (int'(chunk_pos) + 1 >= clen) begin
            if (cur_fmt) begin
                emit_summed(psum[15:8]);
                emit_summed(psum[7:0]);
            end
            emit(fsum[15:8], 1'b0);
            emit(fsum[7:0], 1'b0);
            emit(BYTE_EOF, 1'b0);
            emit(BYTE_EOF, 1'b1);
            if (!resend_q) next_pkt = next_pkt + 16'd1;
            chunk_pos   = '0;
        end else begin
            chunk_pos = chunk_pos + 8'd1;
        end
    endfunction

    function automatic void add_item(input row_kind_t kind, input logic c, input logic [7:0] d,
                                     input logic r, input logic [15:0] l);
        plan.push_back('{kind, c, d, r, l, REG_ECU_ID, 48'h0});
    endfunction

    function automatic void add_cfg(input ufb_reg_t idx, input logic [47:0] val);
        plan.push_back('{DO_CFG, 1'b0, 8'h00, 1'b0, 16'h0, idx, val});
    endfunction

    function automatic logic [47:0] pick_reg_value(input ufb_reg_t idx);
        logic [47:0] v;
        int          k;
        v = {16'($urandom), 32'($urandom)};
        case (idx)
            REG_ECU_ID, REG_TARGET_ID: begin
                k = $urandom_range(0, 7);
                if (k == 0) v = '0;
                else if (k == 1) v = '1;
            end
            REG_SIZE_CODE: begin
                k = $urandom_range(0, 9);
                v = (k < 6) ? 48'(SIZE_32) : (k < 8) ? 48'(SIZE_64) :
                    (k == 8) ? 48'(SIZE_128) : 48'(SIZE_OVER);
            end
            default: v = 48'($urandom_range(0, 1));
        endcase
        return v;
    endfunction

    task automatic log_mismatch(input string what, input logic [7:0] want_v,
                                input logic [7:0] got_v);
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10)
            $display("mismatch on %s: expected %02h, got %02h", what, want_v, got_v);
    endtask

    task automatic issue(input row_kind_t kind, input logic c, input logic [7:0] d,
                         input logic r, input logic [15:0] l);
        in_valid   <= 1'b1;
        cmd        <= c;
        data_byte  <= d;
        resend     <= r;
        lost_index <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_item(c, d, r, l);
        case (kind)
            CHECK_MODEL: foreach (step_beats[k]) frame_q.push_back(step_beats[k]);
            CHECK_ECHO:  frame_q.push_back('{fbyte: d, fend: 1'b0});
            default: ;
        endcase
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic write_reg(input ufb_reg_t idx, input logic [47:0] val);
        in_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ECU_ID:          cur_ecu    = val;
            REG_TARGET_ID:       cur_target = val;
            REG_SIZE_CODE:       cur_size   = val[1:0];
            REG_CHECKSUM_FORMAT: cur_fmt    = val[0];
            REG_BROADCAST:       cur_bcast  = val[0];
            default: ;
        endcase
    endtask

    always @(posedge clk) begin
        frame_beat_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (frame_q.size() == 0) begin
                log_mismatch("beat with nothing expected", 8'h00, frame_byte);
            end else begin
                want = frame_q.pop_front();
                if (frame_byte !== want.fbyte) log_mismatch("frame_byte", want.fbyte, frame_byte);
                if (frame_end !== want.fend)
                    log_mismatch("frame_end", 8'(want.fend), 8'(frame_end));
            end
        end
    end

    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int       n;
        ufb_reg_t idx;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = 1'b0;
        data_byte  = 8'h00;
        resend     = 1'b0;
        lost_index = 16'h0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_ECU_ID;
        cfg_data   = 48'h0;
        cur_ecu    = '0;
        cur_target = '0;
        cur_size   = SIZE_128;
        cur_fmt    = 1'b0;
        cur_bcast  = 1'b0;
        chunk_pos  = '0;
        next_pkt   = '0;
        fsum       = '0;
        psum       = '0;
        resend_q   = 1'b0;
        index_q    = '0;

        // A restart beat never produces output, and a mid-chunk byte comes straight back.
        add_item(CHECK_NONE,  1'b1, 8'h00, 1'b0, 16'h0000);
        add_item(CHECK_MODEL, 1'b0, 8'h00, 1'b0, 16'hFFFF);
        add_item(CHECK_ECHO,  1'b0, 8'hFF, 1'b1, 16'h0000);
        add_item(CHECK_ECHO,  1'b0, 8'h55, 1'b0, 16'h1234);
        add_item(CHECK_NONE,  1'b1, 8'hFF, 1'b1, 16'hFFFF);
        add_cfg(REG_ECU_ID, '1);
        add_cfg(REG_TARGET_ID, 48'h999999999999);
        add_cfg(REG_SIZE_CODE, 48'(SIZE_OVER));
        add_cfg(REG_CHECKSUM_FORMAT, 48'h1);
        add_cfg(REG_BROADCAST, 48'h1);
        add_item(CHECK_MODEL, 1'b0, 8'hAA, 1'b1, 16'hFFFF);
        add_item(CHECK_ECHO,  1'b0, 8'h00, 1'b0, 16'h0000);
        add_item(CHECK_NONE,  1'b1, 8'h00, 1'b0, 16'h0000);
        add_item(CHECK_MODEL, 1'b0, 8'h01, 1'b1, 16'h0000);
        add_item(CHECK_ECHO,  1'b0, 8'h80, 1'b1, 16'h8000);
        add_cfg(REG_SIZE_CODE, 48'(SIZE_64));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (plan[k]) begin
            if (plan[k].kind == DO_CFG)
                write_reg(plan[k].idx, plan[k].val);
            else
                issue(plan[k].kind, plan[k].cmd, plan[k].data, plan[k].resend, plan[k].lost);
        end

        // The first phase leaves a long chunk half built so that the next size write
        // shrinks the chunk below the bytes already taken.
        for (int ph = 0; rand_items < 200; ph++) begin
            if (ph == 1) begin
                write_reg(REG_SIZE_CODE, 48'(SIZE_32));
            end else if (ph > 1) begin
                repeat ($urandom_range(1, 3)) begin
                    idx = ufb_reg_t'($urandom_range(0, 4));
                    write_reg(idx, pick_reg_value(idx));
                end
            end
            n = (ph == 0) ? 40 : $urandom_range(20, 120);
            if (n > 200 - rand_items) n = 200 - rand_items;
            repeat (n) begin
                issue(CHECK_MODEL,
                      (ph != 0) && ($urandom_range(0, 63) == 0),
                      ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                  : 8'($urandom),
                      ($urandom_range(0, 3) == 0),
                      16'($urandom));
                rand_items = rand_items + 1;
            end
        end

        in_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (mismatch_cnt == 0 && frame_q.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
